/* src/nss_pkg.sv */
// Shared types and constants for the nested section skipper.
package nss_pkg;

	localparam int LENGTH_BITS_DEF = 20;
	localparam int DEPTH_BITS_DEF  = 16;
	localparam int ADDR_BITS       = 3;
	localparam int DATA_BITS       = 32;

	localparam logic [7:0] OPEN_RST  = 8'd123;
	localparam logic [7:0] CLOSE_RST = 8'd125;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	// Register index is paddr[2]
	localparam logic REG_OPEN  = 1'b0;
	localparam logic REG_CLOSE = 1'b1;

	typedef enum logic [1:0] {
		CM_NONE  = 2'd0,
		CM_LINE  = 2'd1,
		CM_BLOCK = 2'd2,
		CM_RSVD  = 2'd3
	} cmode_t;

	typedef enum logic [1:0] {
		ST_CLOSED = 2'd0,
		ST_START  = 2'd1,
		ST_STRING = 2'd2,
		ST_NOEND  = 2'd3
	} status_t;

	typedef struct packed {
		logic    emit;
		status_t status;
	} res_t;

endpackage

/* src/nss_cfg.sv */
// APB register file holding the open and close marks.
module nss_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nss_pkg::ADDR_BITS-1:0] paddr,
	input  logic [nss_pkg::DATA_BITS-1:0] pwdata,
	output logic [nss_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	output logic [7:0]                    open_mark,
	output logic [7:0]                    close_mark
);

	logic wr_en;
	logic [7:0] open_q;
	logic [7:0] close_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= nss_pkg::OPEN_RST;
			close_q <= nss_pkg::CLOSE_RST;
		end else if (wr_en) begin
			if (paddr[2] == nss_pkg::REG_OPEN) begin
				open_q <= pwdata[7:0];
			end else begin
				close_q <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == nss_pkg::REG_OPEN) begin
			prdata = {{(nss_pkg::DATA_BITS-8){1'b0}}, open_q};
		end else begin
			prdata = {{(nss_pkg::DATA_BITS-8){1'b0}}, close_q};
		end
	end

	assign open_mark  = open_q;
	assign close_mark = close_q;

endmodule

/* src/nss_core.sv */
// Section scanner state and per-byte next-state logic.
module nss_core #(
	parameter int LENGTH_BITS = nss_pkg::LENGTH_BITS_DEF,
	parameter int DEPTH_BITS  = nss_pkg::DEPTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             txt,
	input  logic                   last,
	input  logic [7:0]             open_mark,
	input  logic [7:0]             close_mark,
	output nss_pkg::res_t          res,
	output logic [LENGTH_BITS-1:0] res_len
);

	logic                   active_q, active_d;
	logic [DEPTH_BITS-1:0]  depth_q, depth_d;
	logic                   in_str_q, in_str_d;
	logic                   esc_q, esc_d;
	nss_pkg::cmode_t        cmode_q, cmode_d;
	logic                   slash_q, slash_d;
	logic                   star_q, star_d;
	logic [LENGTH_BITS-1:0] count_q, count_d;
	logic                   clr;
	logic                   done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			depth_q  <= '0;
			in_str_q <= 1'b0;
			esc_q    <= 1'b0;
			cmode_q  <= nss_pkg::CM_NONE;
			slash_q  <= 1'b0;
			star_q   <= 1'b0;
			count_q  <= '0;
		end else if (step) begin
			active_q <= active_d;
			depth_q  <= depth_d;
			in_str_q <= in_str_d;
			esc_q    <= esc_d;
			cmode_q  <= cmode_d;
			slash_q  <= slash_d;
			star_q   <= star_d;
			count_q  <= count_d;
		end
	end

	always_comb begin
		active_d   = active_q;
		depth_d    = depth_q;
		in_str_d   = in_str_q;
		esc_d      = esc_q;
		cmode_d    = cmode_q;
		slash_d    = slash_q;
		star_d     = star_q;
		count_d    = count_q;
		res.emit   = 1'b0;
		res.status = nss_pkg::ST_CLOSED;
		res_len    = '0;
		clr        = 1'b0;
		done       = 1'b0;

		if (!active_q) begin
			if (txt != open_mark) begin
				res.emit   = 1'b1;
				res.status = nss_pkg::ST_START;
				clr        = 1'b1;
			end else begin
				active_d = 1'b1;
				depth_d  = DEPTH_BITS'(1);
				in_str_d = 1'b0;
				esc_d    = 1'b0;
				cmode_d  = nss_pkg::CM_NONE;
				slash_d  = 1'b0;
				star_d   = 1'b0;
				count_d  = LENGTH_BITS'(1);
				if (last) begin
					res.emit   = 1'b1;
					res.status = nss_pkg::ST_NOEND;
					clr        = 1'b1;
				end
			end
		end else begin
			if (count_q != '1) begin
				count_d = count_q + LENGTH_BITS'(1);
			end

			if (cmode_q == nss_pkg::CM_LINE) begin
				if (txt == nss_pkg::CH_LF || txt == nss_pkg::CH_CR) begin
					cmode_d = nss_pkg::CM_NONE;
				end
			end else if (cmode_q == nss_pkg::CM_BLOCK) begin
				// a star swallows the following byte; only a slash ends the comment
				if (star_q) begin
					star_d = 1'b0;
					if (txt == nss_pkg::CH_SLASH) begin
						cmode_d = nss_pkg::CM_NONE;
					end
				end else if (txt == nss_pkg::CH_STAR) begin
					star_d = 1'b1;
				end
			end else if (slash_q && txt == nss_pkg::CH_SLASH) begin
				slash_d = 1'b0;
				cmode_d = nss_pkg::CM_LINE;
			end else if (slash_q && txt == nss_pkg::CH_STAR) begin
				slash_d = 1'b0;
				cmode_d = nss_pkg::CM_BLOCK;
			end else begin
				slash_d = 1'b0;
				esc_d   = 1'b0;
				if (txt == nss_pkg::CH_QUOTE) begin
					if (!esc_q) begin
						in_str_d = !in_str_q;
					end
				end else if (in_str_q) begin
					if (!esc_q) begin
						if (txt == nss_pkg::CH_LF || txt == nss_pkg::CH_CR) begin
							res.emit   = 1'b1;
							res.status = nss_pkg::ST_STRING;
							clr        = 1'b1;
							done       = 1'b1;
						end else if (txt == nss_pkg::CH_BSLASH) begin
							esc_d = 1'b1;
						end
					end
				end else if (txt == nss_pkg::CH_SLASH) begin
					slash_d = 1'b1;
				end else if (txt == open_mark) begin
					if (depth_q != '1) begin
						depth_d = depth_q + DEPTH_BITS'(1);
					end
				end else if (txt == close_mark) begin
					if (depth_q != '0) begin
						depth_d = depth_q - DEPTH_BITS'(1);
					end
					if (depth_d == '0) begin
						res.emit   = 1'b1;
						res.status = nss_pkg::ST_CLOSED;
						res_len    = count_d;
						clr        = 1'b1;
						done       = 1'b1;
					end
				end
			end

			if (!done && last) begin
				res.emit = 1'b1;
				if (in_str_d) begin
					res.status = nss_pkg::ST_STRING;
				end else begin
					res.status = nss_pkg::ST_NOEND;
				end
				clr = 1'b1;
			end
		end

		// drop all section state once a result goes out
		if (clr) begin
			active_d = 1'b0;
			depth_d  = '0;
			in_str_d = 1'b0;
			esc_d    = 1'b0;
			cmode_d  = nss_pkg::CM_NONE;
			slash_d  = 1'b0;
			star_d   = 1'b0;
			count_d  = '0;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (depth_q == '0 && count_q == '0 && !in_str_q))
		else $error("idle scanner holds section state");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.emit) |=> !active_q)
		else $error("scanner stays active after a result");

	a_comment_no_str: assert property (@(posedge clk) disable iff (!arst_n)
		cmode_q != nss_pkg::CM_NONE |-> !in_str_q)
		else $error("comment and string open together");

	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (count_q != '0 && depth_q != '0))
		else $error("active section with zero count or depth");

endmodule

/* src/nested_section_skipper.sv */
// Top level: input stage, section scanner and registered result with APB marks.
// A byte from s_* waits in the input stage; its result is registered onto m_*.
// Throughput: one byte per cycle unless a result waits on m_tready; the scanner
// steps once per byte; a held result stalls input only when the input stage is full.
// Reset: arst_n clears the scanner to await a section start, empties both stages
// and restores open mark 123 and close mark 125.
module nested_section_skipper #(
	parameter int LENGTH_BITS = nss_pkg::LENGTH_BITS_DEF,
	parameter int DEPTH_BITS  = nss_pkg::DEPTH_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,  // [7:0] text_byte
	input  logic                                 s_tlast,  // last_byte
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((LENGTH_BITS+7)/8)*8-1:0]     m_tdata,  // [LENGTH_BITS-1:0] length
	output logic [1:0]                           m_tuser,  // [1:0] status
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [nss_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [nss_pkg::DATA_BITS-1:0]        pwdata,
	output logic [nss_pkg::DATA_BITS-1:0]        prdata,
	output logic                                 pready
);

	localparam int TDATA_BITS = ((LENGTH_BITS + 7) / 8) * 8;

	logic                   v_s1;
	logic [7:0]             txt_s1;
	logic                   last_s1;
	logic                   out_v_q;
	nss_pkg::status_t       status_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic                   advance;
	logic                   step;
	logic                   in_xfer;
	logic [7:0]             open_mark;
	logic [7:0]             close_mark;
	nss_pkg::res_t          res;
	logic [LENGTH_BITS-1:0] res_len;

	nss_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.open_mark  (open_mark),
		.close_mark (close_mark)
	);

	nss_core #(
		.LENGTH_BITS (LENGTH_BITS),
		.DEPTH_BITS  (DEPTH_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.txt        (txt_s1),
		.last       (last_s1),
		.open_mark  (open_mark),
		.close_mark (close_mark),
		.res        (res),
		.res_len    (res_len)
	);

	// the scanned byte may move on whenever the result slot is free or draining
	assign advance  = !out_v_q || m_tready;
	assign step     = v_s1 && advance;
	assign s_tready = !v_s1 || advance;
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_xfer) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			txt_s1  <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (step) begin
			out_v_q <= res.emit;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			status_q <= res.status;
			len_q    <= res_len;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = status_q;
	assign m_tdata  = TDATA_BITS'(len_q);

endmodule

/* tb/sv/nested_section_skipper_tb.sv */
// Testbench for nested_section_skipper: bracket sections checked against a scoreboard.
module nested_section_skipper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TDATA_W = ((nss_pkg::LENGTH_BITS_DEF + 7) / 8) * 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		nss_pkg::status_t                    status;
		logic [nss_pkg::LENGTH_BITS_DEF-1:0] length;
	} section_result_t;

	typedef enum {SCAN_MORE, SCAN_CLOSED, SCAN_BAD_STRING} scan_t;

	class section_scoreboard;
		logic [7:0] open_mark;
		logic [7:0] close_mark;
		bit active;
		bit in_str;
		bit esc_pend;
		bit slash_pend;
		bit star_pend;
		nss_pkg::cmode_t cmode;
		logic [nss_pkg::DEPTH_BITS_DEF-1:0] depth;
		logic [nss_pkg::LENGTH_BITS_DEF-1:0] byte_cnt;
		section_result_t pending_results[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned status_seen[4];

		function void clear_section();
			active = 1'b0;
			depth = '0;
			in_str = 1'b0;
			esc_pend = 1'b0;
			cmode = nss_pkg::CM_NONE;
			slash_pend = 1'b0;
			star_pend = 1'b0;
			byte_cnt = '0;
		endfunction

		function void restore_marks();
			open_mark = nss_pkg::OPEN_RST;
			close_mark = nss_pkg::CLOSE_RST;
			clear_section();
		endfunction

		function void write_mark(logic idx, logic [7:0] v);
			if (idx == nss_pkg::REG_OPEN)
				open_mark = v;
			else
				close_mark = v;
		endfunction

		function void expect_result(nss_pkg::status_t st,
			logic [nss_pkg::LENGTH_BITS_DEF-1:0] len);
			section_result_t r;
			r.status = st;
			r.length = len;
			pending_results.push_back(r);
			clear_section();
		endfunction

		function scan_t scan_byte(logic [7:0] b);
			if (cmode == nss_pkg::CM_LINE) begin
				if (b == nss_pkg::CH_LF || b == nss_pkg::CH_CR)
					cmode = nss_pkg::CM_NONE;
				return SCAN_MORE;
			end
			if (cmode == nss_pkg::CM_BLOCK) begin
				// a star swallows the byte after it
				if (star_pend) begin
					star_pend = 1'b0;
					if (b == nss_pkg::CH_SLASH)
						cmode = nss_pkg::CM_NONE;
				end else if (b == nss_pkg::CH_STAR) begin
					star_pend = 1'b1;
				end
				return SCAN_MORE;
			end
			if (slash_pend) begin
				slash_pend = 1'b0;
				if (b == nss_pkg::CH_SLASH) begin
					cmode = nss_pkg::CM_LINE;
					return SCAN_MORE;
				end
				if (b == nss_pkg::CH_STAR) begin
					cmode = nss_pkg::CM_BLOCK;
					return SCAN_MORE;
				end
			end
			if (b == nss_pkg::CH_QUOTE) begin
				if (!esc_pend)
					in_str = !in_str;
			end else if (in_str) begin
				if (!esc_pend) begin
					if (b == nss_pkg::CH_LF || b == nss_pkg::CH_CR)
						return SCAN_BAD_STRING;
					if (b == nss_pkg::CH_BSLASH) begin
						esc_pend = 1'b1;
						return SCAN_MORE;
					end
				end
			end else if (b == nss_pkg::CH_SLASH) begin
				slash_pend = 1'b1;
			end else if (b == open_mark) begin
				if (depth != '1)
					depth++;
			end else if (b == close_mark) begin
				if (depth != '0)
					depth--;
				if (depth == '0) begin
					esc_pend = 1'b0;
					return SCAN_CLOSED;
				end
			end
			esc_pend = 1'b0;
			return SCAN_MORE;
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			scan_t r;
			if (!active) begin
				if (b != open_mark) begin
					expect_result(nss_pkg::ST_START, '0);
					return;
				end
				clear_section();
				active = 1'b1;
				depth = nss_pkg::DEPTH_BITS_DEF'(1);
				byte_cnt = nss_pkg::LENGTH_BITS_DEF'(1);
				if (last)
					expect_result(nss_pkg::ST_NOEND, '0);
				return;
			end
			if (byte_cnt != '1)
				byte_cnt++;
			r = scan_byte(b);
			if (r == SCAN_CLOSED)
				expect_result(nss_pkg::ST_CLOSED, byte_cnt);
			else if (r == SCAN_BAD_STRING)
				expect_result(nss_pkg::ST_STRING, '0);
			else if (last) begin
				if (in_str)
					expect_result(nss_pkg::ST_STRING, '0);
				else
					expect_result(nss_pkg::ST_NOEND, '0);
			end
		endfunction

		function void report(string what, longint unsigned want, longint unsigned got);
			errors++;
			if (errors <= 10)
				$display("MISMATCH %s: expected %0d, got %0d (result %0d)",
					what, want, got, checked);
		endfunction

		function void check_result(logic [1:0] st, logic [TDATA_W-1:0] data);
			section_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("MISMATCH unexpected result: status %0d, length %0d", st, data);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			status_seen[want.status]++;
			if (st !== want.status)
				report("status", want.status, st);
			if (data !== TDATA_W'(want.length))
				report("length", want.length, data);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;  // [7:0] text_byte
	logic s_tlast = 1'b0;      // last_byte
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;  // [LENGTH_BITS-1:0] length
	logic [1:0] m_tuser;          // [1:0] status
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [nss_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [nss_pkg::DATA_BITS-1:0] pwdata = '0;
	logic [nss_pkg::DATA_BITS-1:0] prdata;
	logic pready;

	section_scoreboard sb;
	logic [8:0] section_q[$];  // {last, byte}
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycle_count = 0;

	nested_section_skipper u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Sample both streams on the pre-edge values, then pick the next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(string s, bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last_at_end && (i == s.len() - 1));
	endtask

	// Drain every expected transfer, then cover bytes that give no result
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mark(logic idx, logic [7:0] v);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom()), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_mark(idx, v);
	endtask

	task automatic pick_marks();
		case ($urandom_range(0, 4))
		0: begin
			set_mark(nss_pkg::REG_OPEN, "{");
			set_mark(nss_pkg::REG_CLOSE, "}");
		end
		1: begin
			set_mark(nss_pkg::REG_OPEN, "(");
			set_mark(nss_pkg::REG_CLOSE, ")");
		end
		2: begin
			set_mark(nss_pkg::REG_OPEN, "[");
			set_mark(nss_pkg::REG_CLOSE, "]");
		end
		3: begin
			set_mark(nss_pkg::REG_OPEN, "<");
			set_mark(nss_pkg::REG_CLOSE, ">");
		end
		default: begin
			set_mark(nss_pkg::REG_OPEN, 8'($urandom_range(0, 255)));
			set_mark(nss_pkg::REG_CLOSE, 8'($urandom_range(0, 255)));
		end
		endcase
	endtask

	function automatic logic [7:0] filler();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == nss_pkg::CH_QUOTE || b == nss_pkg::CH_BSLASH ||
			b == nss_pkg::CH_LF || b == nss_pkg::CH_CR ||
			b == nss_pkg::CH_SLASH || b == nss_pkg::CH_STAR ||
			b == sb.open_mark || b == sb.close_mark);
		return b;
	endfunction

	function automatic logic [7:0] comment_byte();
		case ($urandom_range(0, 7))
		0: return sb.open_mark;
		1: return sb.close_mark;
		2: return nss_pkg::CH_STAR;
		3: return nss_pkg::CH_QUOTE;
		4: return nss_pkg::CH_SLASH;
		default: return filler();
		endcase
	endfunction

	function automatic void push_byte(logic [7:0] b);
		section_q.push_back({1'b0, b});
	endfunction

	// Mostly well-formed sections with random content; some noise and truncation
	task automatic build_section();
		int d;
		int steps;
		section_q.delete();
		if ($urandom_range(99) < 12) begin
			section_q.push_back({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
			return;
		end
		push_byte(sb.open_mark);
		d = 1;
		steps = $urandom_range(3, 30);
		while (d > 0 && steps > 0) begin
			steps--;
			case ($urandom_range(0, 9))
			0, 1: push_byte(filler());
			2: begin
				if (d < 6) begin
					push_byte(sb.open_mark);
					d++;
				end else begin
					push_byte(filler());
				end
			end
			3, 4: begin
				push_byte(sb.close_mark);
				d--;
			end
			5: begin
				push_byte(nss_pkg::CH_QUOTE);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 19))
					0: push_byte($urandom_range(0, 1) ? nss_pkg::CH_LF : nss_pkg::CH_CR);
					1, 2: begin
						push_byte(nss_pkg::CH_BSLASH);
						push_byte(8'($urandom_range(0, 255)));
					end
					3: push_byte($urandom_range(0, 1) ? sb.open_mark : sb.close_mark);
					default: push_byte(filler());
					endcase
				end
				if ($urandom_range(9) != 0)
					push_byte(nss_pkg::CH_QUOTE);
			end
			6: begin
				push_byte(nss_pkg::CH_SLASH);
				push_byte(nss_pkg::CH_SLASH);
				repeat ($urandom_range(0, 5)) push_byte(comment_byte());
				push_byte($urandom_range(0, 1) ? nss_pkg::CH_LF : nss_pkg::CH_CR);
			end
			7: begin
				push_byte(nss_pkg::CH_SLASH);
				push_byte(nss_pkg::CH_STAR);
				repeat ($urandom_range(0, 6)) push_byte(comment_byte());
				push_byte(nss_pkg::CH_STAR);
				push_byte(nss_pkg::CH_SLASH);
			end
			8: begin
				push_byte(nss_pkg::CH_SLASH);
				push_byte(filler());
			end
			default: push_byte(8'($urandom_range(0, 255)));
			endcase
		end
		if ($urandom_range(99) < (d > 0 ? 70 : 15))
			section_q[section_q.size() - 1][8] = 1'b1;
		if ($urandom_range(99) < 5)
			section_q[$urandom_range(0, section_q.size() - 1)][8] = 1'b1;
	endtask

	task automatic run_random(int unsigned n_bytes);
		int unsigned target;
		pick_marks();
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			build_section();
			foreach (section_q[k])
				send_byte(section_q[k][7:0], section_q[k][8]);
		end
	endtask

	initial begin
		sb = new;
		sb.restore_marks();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 38;
		recv_idle = 78;
		send_text("{}", 0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_text("{", 1);
		send_text("{\"a\nb}", 0);
		send_text("{\"x", 0);
		send_byte(nss_pkg::CH_CR, 1'b1);
		send_text("{\"ab", 1);
		send_text("{// }", 0);
		send_byte(nss_pkg::CH_CR, 1'b0);
		send_text("}", 0);
		send_text("{/*}*}*/}", 0);
		send_text("{/x}", 0);
		send_text("{\"\\\"}\"}", 0);
		send_text("{\"\\\n\"}", 0);
		send_text("{{/", 1);
		send_text("{/**", 1);
		send_byte("{", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("}", 0);
		send_text("{// x}", 1);

		// extreme marks
		set_mark(nss_pkg::REG_OPEN, 8'h00);
		set_mark(nss_pkg::REG_CLOSE, 8'hFF);
		send_byte(8'h00, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		set_mark(nss_pkg::REG_OPEN, 8'hFF);
		set_mark(nss_pkg::REG_CLOSE, 8'h00);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		// equal marks: open wins
		set_mark(nss_pkg::REG_OPEN, "x");
		set_mark(nss_pkg::REG_CLOSE, "x");
		send_text("xx", 1);
		// marks that collide with quote and slash
		set_mark(nss_pkg::REG_OPEN, nss_pkg::CH_QUOTE);
		set_mark(nss_pkg::REG_CLOSE, nss_pkg::CH_SLASH);
		send_text("\"ab\"c/", 1);

		repeat (3) run_random(100);

		send_idle = 78;
		recv_idle = 38;
		repeat (3) run_random(100);

		send_idle = 0;
		recv_idle = 0;
		// nest deeply, then unwind
		set_mark(nss_pkg::REG_OPEN, nss_pkg::OPEN_RST);
		set_mark(nss_pkg::REG_CLOSE, nss_pkg::CLOSE_RST);
		repeat (20) send_byte(nss_pkg::OPEN_RST, 1'b0);
		repeat (20) send_byte(nss_pkg::CLOSE_RST, 1'b0);
		repeat (3) run_random(100);

		settle();
		$display("Sent %0d text bytes under three idle profiles; %0d results checked",
			bytes_sent, sb.checked);
		$display("Results: %0d closed, %0d bad start, %0d unclosed string, %0d missing end",
			sb.status_seen[nss_pkg::ST_CLOSED], sb.status_seen[nss_pkg::ST_START],
			sb.status_seen[nss_pkg::ST_STRING], sb.status_seen[nss_pkg::ST_NOEND]);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
src/nss_pkg.sv
src/nss_cfg.sv
src/nss_core.sv
src/nested_section_skipper.sv
tb/sv/nested_section_skipper_tb.sv
